[hw/rtl/ipv4_lpm_forward_decision_unit_assert.svh]
// assertion macros used by the forward decision unit checker
`ifndef IPV4_LPM_FORWARD_DECISION_UNIT_ASSERT_SVH
`define IPV4_LPM_FORWARD_DECISION_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define LPMFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that also looks at the reset itself
`define LPMFD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/lpmfd_pkg.sv]
// types, constants and defaults of the forward decision unit
`timescale 1ns / 1ps

package lpmfd_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int PORTS_DEF   = 16;

    localparam logic [1:0] VERDICT_FORWARD      = 2'd0;
    localparam logic [1:0] VERDICT_TTL_EXCEEDED = 2'd1;
    localparam logic [1:0] VERDICT_NET_UNREACH  = 2'd2;
    localparam logic [1:0] VERDICT_WRITE_DONE   = 2'd3;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_FORWARD = 1'b1;

    // lowest ttl that may still be forwarded is one above this
    localparam logic [7:0] TTL_LIMIT = 8'd1;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  entry_slot;
        logic        entry_valid;
        logic [31:0] entry_prefix;
        logic [31:0] entry_netmask;
        logic [31:0] entry_gateway;
        logic [3:0]  entry_port;
        logic [31:0] pkt_dst;
        logic [7:0]  pkt_ttl;
    } t_req;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] hop_addr;
        logic [3:0]  out_port;
        logic [7:0]  new_ttl;
    } t_result;

    // one route as held in the table ram
    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [3:0]  port;
    } t_route;

    localparam int ROUTE_W = $bits(t_route);

    typedef struct packed {
        logic load;
        logic wr_en;
        logic rd_en;
        logic cmp_en;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_write;
        logic ttl_expired;
    } t_dp_status;

endpackage

[hw/rtl/lpmfd_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lpmfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lpmfd_ctrl.sv]
// sequencer for write, ttl check and table scan
`timescale 1ns / 1ps

module lpmfd_ctrl import lpmfd_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_dp_status    i_status,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_rd_addr,
    output logic          o_busy
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_LAST     = 3'd3;
    localparam logic [2:0] ST_RESP     = 3'd4;

    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_cmp_en, n_cmp_en;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cmp_en = 1'b0;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_idx = '0;
                if (i_status.is_write) begin
                    o_cmd.wr_en = 1'b1;
                    n_state     = ST_RESP;
                end else if (i_status.ttl_expired) begin
                    n_state = ST_RESP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.cmp_en = r_cmp_en;
                n_cmp_en    = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_LAST;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LAST: begin
                o_cmd.cmp_en = r_cmp_en;
                n_state      = ST_RESP;
            end
            ST_RESP: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_cmp_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cmp_en <= n_cmp_en;
        end
    end

    assign o_rd_addr = r_idx;
    assign o_busy    = (r_state != ST_IDLE);

endmodule

[hw/rtl/lpmfd_dp.sv]
// route table, best match registers and result register
`timescale 1ns / 1ps

module lpmfd_dp import lpmfd_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int PORTS   = PORTS_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_req          i_req,
    input  t_dp_cmd       i_cmd,
    input  logic [AW-1:0] i_rd_addr,
    output t_dp_status    o_status,
    output t_result       o_result,
    output logic          o_done
);

    t_req             r_req;
    logic [ENTRIES-1:0] r_valid;
    logic             r_rd_vld;
    logic             r_found;
    logic [31:0]      r_best_mask;
    logic [31:0]      r_best_gw;
    logic [3:0]       r_best_port;
    t_result          r_result, n_result;
    logic             r_done;

    logic [8:0]       slot_ext;
    logic [8:0]       port_ext;
    logic             wr_ok;
    logic             ram_we;
    t_route           wr_route;
    t_route           rd_route;
    logic             hit;
    logic             better;

    // write is dropped when slot lies beyond the table or port beyond PORTS
    assign slot_ext = {5'b0, r_req.entry_slot};
    assign port_ext = {5'b0, r_req.entry_port};
    assign wr_ok    = (slot_ext < 9'(ENTRIES)) && (port_ext < 9'(PORTS));
    assign ram_we   = i_cmd.wr_en && wr_ok;

    assign wr_route.prefix  = r_req.entry_prefix;
    assign wr_route.netmask = r_req.entry_netmask;
    assign wr_route.gateway = r_req.entry_gateway;
    assign wr_route.port    = r_req.entry_port;

    lpmfd_ram #(
        .WIDTH (ROUTE_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata (wr_route),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_route)
    );

    // strictly larger mask replaces, so the lowest index keeps a tie
    assign hit    = r_rd_vld &&
                    (((r_req.pkt_dst ^ rd_route.prefix) & rd_route.netmask) == 32'd0);
    assign better = !r_found || (r_best_mask < rd_route.netmask);

    assign o_status.is_write    = (r_req.req_type == REQ_WRITE);
    assign o_status.ttl_expired = (r_req.pkt_ttl <= TTL_LIMIT);

    always_comb begin
        n_result.verdict  = VERDICT_WRITE_DONE;
        n_result.hop_addr = '0;
        n_result.out_port = '0;
        n_result.new_ttl  = r_req.pkt_ttl;
        if (r_req.req_type == REQ_WRITE) begin
            n_result.verdict = VERDICT_WRITE_DONE;
        end else if (o_status.ttl_expired) begin
            n_result.verdict = VERDICT_TTL_EXCEEDED;
        end else if (!r_found) begin
            n_result.verdict = VERDICT_NET_UNREACH;
        end else begin
            n_result.verdict  = VERDICT_FORWARD;
            n_result.hop_addr = (r_best_gw != 32'd0) ? r_best_gw : r_req.pkt_dst;
            n_result.out_port = r_best_port;
            n_result.new_ttl  = r_req.pkt_ttl - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (ram_we) begin
                r_valid[slot_ext[AW-1:0]] <= r_req.entry_valid;
            end
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (i_cmd.cmp_en && hit && better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.rd_en) begin
            r_rd_vld <= r_valid[i_rd_addr];
        end
        if (i_cmd.cmp_en && hit && better) begin
            r_best_mask <= rd_route.netmask;
            r_best_gw   <= rd_route.gateway;
            r_best_port <= rd_route.port;
        end
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

[hw/rtl/ipv4_lpm_forward_decision_unit.sv]
// top level of the ipv4 longest prefix match forward decision unit
//
//  channel   | handshake        | payload   | direction
//  ----------+------------------+-----------+----------
//  request   | start / busy     | i_req     | in
//  result    | o_done (strobe)  | o_result  | out
//
// a transaction is taken at the edge where start is high and busy is low
// lookup: dispatch, a scan that reads one route per cycle through the single
//   ram read port, a last compare and the response before the next acceptance
// write and ttl exceeded: dispatch then response, no scan
// synchronous active low reset clears the valid bits and the sequencer
// the result is shown for exactly one cycle on o_done; the receiver cannot stall
`timescale 1ns / 1ps

module ipv4_lpm_forward_decision_unit import lpmfd_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int PORTS   = PORTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_done,
    output t_result o_result
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // command and status between sequencer and datapath
    t_dp_cmd       cmd;
    t_dp_status    status;
    logic [AW-1:0] rd_addr;

    // sequencer: dispatch, for lookups one route per scan step and a last compare, then response
    lpmfd_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_busy    (busy)
    );

    // datapath: route table ram, valid bits, best match and result register
    lpmfd_dp #(
        .ENTRIES (ENTRIES),
        .PORTS   (PORTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .o_status  (status),
        .o_result  (o_result),
        .o_done    (o_done)
    );

endmodule

[hw/rtl/lpmfd_chk.sv]
// port level checks of the forward decision unit, bound to the top level
`timescale 1ns / 1ps
`include "ipv4_lpm_forward_decision_unit_assert.svh"

module lpmfd_chk import lpmfd_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    `LPMFD_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !busy && !o_done, "busy or done after reset")
    `LPMFD_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")
    `LPMFD_ASSERT(a_done_single, o_done |=> !o_done, "result strobe longer than one cycle")
    `LPMFD_ASSERT(a_done_after_work, o_done |-> $past(busy), "result without preceding work")
    `LPMFD_ASSERT(a_no_hop_unless_fwd, o_done && (o_result.verdict != VERDICT_FORWARD) |-> (o_result.hop_addr == 32'd0) && (o_result.out_port == 4'd0), "next hop or port set without forwarding")

endmodule

bind ipv4_lpm_forward_decision_unit lpmfd_chk u_lpmfd_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
